FILE: rtl/core/cvxh_pkg.sv
// Package for the convex hull block: state machine encoding and small helpers.
// Used by cvxh_orient and convex_hull_graham_scan.
package cvxh_pkg;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_CMP,
    ST_SORT_INIT,
    ST_SORT_T,
    ST_SORT_C,
    ST_SORT_CMP,
    ST_SORT_WAIT,
    ST_SORT_PUT,
    ST_SCAN_RD,
    ST_SCAN_TOP,
    ST_SCAN_CMP,
    ST_SCAN_WAIT,
    ST_SCAN_PUSH,
    ST_OUT_RD,
    ST_OUT_SHOW,
    ST_EMPTY
  } cvxh_state_t;

  // Orientation sign codes.
  typedef enum logic [1:0] {
    ORI_ZERO = 2'd0,
    ORI_POS  = 2'd1,
    ORI_NEG  = 2'd2
  } cvxh_sign_t;

  // Control from the sequencer to the shared orientation unit.
  typedef struct packed {
    logic start;
  } cvxh_orient_ctl_t;

endpackage

FILE: rtl/core/cvxh_orient.sv
// Shared orientation unit: sign of (b.y-a.y)*(c.x-b.x) - (b.x-a.x)*(c.y-b.y).
// The differences and the products are registered; depends on cvxh_pkg.
module cvxh_orient
  import cvxh_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cvxh_orient_ctl_t             ctl,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output logic                         done,
  output cvxh_sign_t                   sign
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic              s1, s2;
  logic signed [DW-1:0] d0, d1, d2, d3;
  logic signed [PW-1:0] p, q;
  logic signed [PW:0]   diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
    end else begin
      s1 <= ctl.start;
      s2 <= s1;
    end
    d0 <= DW'(by) - DW'(ay);
    d1 <= DW'(cx) - DW'(bx);
    d2 <= DW'(bx) - DW'(ax);
    d3 <= DW'(cy) - DW'(by);
    p  <= d0 * d1;
    q  <= d2 * d3;
  end

  assign diff = (PW+1)'(p) - (PW+1)'(q);
  assign done = s2;
  always_comb begin
    if (diff[PW]) sign = ORI_NEG;
    else if (diff != '0) sign = ORI_POS;
    else sign = ORI_ZERO;
  end

endmodule

FILE: rtl/core/convex_hull_graham_scan.sv
// Graham scan convex hull over up to MAX_POINTS points, one point per input item, the last
// flagged with tlast. Loading accepts one item per cycle; points past MAX_POINTS are
// dropped. After the last item the block finds the pivot, swaps it to the front and
// insertion-sorts the rest: each point is fetched and placed, and every compare fetches an
// index and a point and then waits on the shared orientation unit. The stack scan fetches
// each point and runs one orientation test per pop and one per push once two vertices are
// stacked. Each vertex is then fetched and held until it is taken. Points and the
// order/stack indices live in memories with a registered read; no input item is accepted
// until the last result has been taken.
// Depends on cvxh_pkg and cvxh_orient.
module convex_hull_graham_scan
  import cvxh_pkg::*;
#(
  parameter int MAX_POINTS = 8,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,  // point_x, point_y
  input  logic s_tlast,                                // point_last
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,  // hull_x, hull_y
  output logic m_tlast,                                // hull_last
  output logic m_tuser                                 // hull_empty
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = ((2*COORD_BITS+7)/8)*8;
  localparam int PW = 2 * COORD_BITS;
  localparam int MW = COORD_BITS + 2;

  // Memories: points, and the sort order that the scan turns into the hull stack in place.
  logic [PW-1:0] pmem [MAX_POINTS];
  logic [IW-1:0] omem [MAX_POINTS];
  logic [PW-1:0] prd;
  logic [IW-1:0] ord;

  cvxh_state_t state, state_next;
  logic [CW-1:0] count, n, i, j, d, n_load;
  logic [IW-1:0] piv, t_idx, c_idx;
  logic [PW-1:0] piv_pt, a_pt, b_pt, c_pt;
  logic [1:0]    rd_ph;

  logic          pw_en;
  logic [IW-1:0] pw_addr, pr_addr, ow_addr, or_addr;
  logic [PW-1:0] pw_data;
  logic          ow_en;
  logic [IW-1:0] ow_data;

  logic s_fire, m_fire;
  logic out_valid;
  logic out_last, out_empty;
  logic [PW-1:0] out_pt;

  always_ff @(posedge clk) begin
    if (pw_en) pmem[pw_addr] <= pw_data;
    prd <= pmem[pr_addr];
    if (ow_en) omem[ow_addr] <= ow_data;
    ord <= omem[or_addr];
  end

  cvxh_orient_ctl_t octl;
  logic       odone;
  cvxh_sign_t osign;

  // Sort: (pivot, t, order[j-1]); scan: (h[d-2], h[d-1], p).
  cvxh_orient #(.COORD_BITS(COORD_BITS)) u_orient (
    .clk(clk), .rst(rst), .ctl(octl),
    .ax(a_pt[COORD_BITS-1:0]), .ay(a_pt[PW-1:COORD_BITS]),
    .bx(b_pt[COORD_BITS-1:0]), .by(b_pt[PW-1:COORD_BITS]),
    .cx(c_pt[COORD_BITS-1:0]), .cy(c_pt[PW-1:COORD_BITS]),
    .done(odone), .sign(osign)
  );

  function automatic logic [MW-1:0] l1d(input logic [PW-1:0] p, input logic [PW-1:0] q);
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0] ax, ay;
    dx = (COORD_BITS+1)'($signed(p[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(q[COORD_BITS-1:0]));
    dy = (COORD_BITS+1)'($signed(p[PW-1:COORD_BITS])) - (COORD_BITS+1)'($signed(q[PW-1:COORD_BITS]));
    ax = dx[COORD_BITS] ? -dx : dx;
    ay = dy[COORD_BITS] ? -dy : dy;
    return MW'(ax) + MW'(ay);
  endfunction

  logic less_pt;
  assign less_pt = ($signed(prd[COORD_BITS-1:0]) < $signed(piv_pt[COORD_BITS-1:0])) ||
                   ((prd[COORD_BITS-1:0] == piv_pt[COORD_BITS-1:0]) &&
                    ($signed(prd[PW-1:COORD_BITS]) < $signed(piv_pt[PW-1:COORD_BITS])));

  // Collinear points sort nearer-first.
  logic before_t;
  assign before_t = (osign == ORI_POS) ||
                    ((osign == ORI_ZERO) && (l1d(b_pt, piv_pt) < l1d(c_pt, piv_pt)));

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;
  assign s_tready = (state == ST_LOAD);
  assign n_load = (count < CW'(MAX_POINTS)) ? count + CW'(1) : count;

  assign m_tvalid = out_valid;
  assign m_tdata  = TW'(out_pt);
  assign m_tlast  = out_last;
  assign m_tuser  = out_empty;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pw_en = 1'b0; pw_addr = count[IW-1:0]; pw_data = s_tdata[PW-1:0];
    pr_addr = '0; ow_en = 1'b0; ow_addr = '0; ow_data = '0; or_addr = '0;
    octl.start = 1'b0;
    unique case (state)
      ST_LOAD: begin
        pw_en = s_fire && (count < CW'(MAX_POINTS));
        if (s_fire && s_tlast) state_next = (n_load < CW'(3)) ? ST_EMPTY : ST_PIV_RD;
      end
      ST_PIV_RD: begin
        // Read point i and start the order array as the identity.
        pr_addr = i[IW-1:0];
        ow_en = 1'b1; ow_addr = i[IW-1:0]; ow_data = i[IW-1:0];
        state_next = ST_PIV_CMP;
      end
      ST_PIV_CMP: begin
        state_next = (i + CW'(1) == n) ? ST_SORT_INIT : ST_PIV_RD;
      end
      ST_SORT_INIT: begin
        ow_en = 1'b1;
        if (rd_ph == 2'd0) begin
          ow_addr = piv; ow_data = '0;
        end else begin
          ow_addr = '0; ow_data = piv;
          state_next = ST_SORT_T;
        end
      end
      ST_SORT_T: begin
        or_addr = i[IW-1:0];
        pr_addr = ord;
        if (rd_ph == 2'd2) state_next = ST_SORT_C;
      end
      ST_SORT_C: begin
        or_addr = IW'(j - CW'(1));
        pr_addr = ord;
        if (rd_ph == 2'd0 && j == CW'(1)) state_next = ST_SORT_PUT;
        else if (rd_ph == 2'd2) state_next = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        octl.start = 1'b1;
        state_next = ST_SORT_WAIT;
      end
      ST_SORT_WAIT: begin
        if (odone) begin
          if (before_t) begin
            ow_en = 1'b1; ow_addr = j[IW-1:0]; ow_data = c_idx;
            state_next = ST_SORT_C;
          end else begin
            state_next = ST_SORT_PUT;
          end
        end
      end
      ST_SORT_PUT: begin
        ow_en = 1'b1; ow_addr = j[IW-1:0]; ow_data = t_idx;
        state_next = (i + CW'(1) < n) ? ST_SORT_T : ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        or_addr = i[IW-1:0];
        pr_addr = ord;
        if (rd_ph == 2'd2) state_next = ST_SCAN_TOP;
      end
      ST_SCAN_TOP: begin
        // The stack sits in omem[0..d-1]; it never passes i, so order[i] is read first.
        or_addr = (rd_ph == 2'd0) ? IW'(d - CW'(2)) : IW'(d - CW'(1));
        pr_addr = ord;
        if (rd_ph == 2'd0 && d < CW'(2)) state_next = ST_SCAN_PUSH;
        else if (rd_ph == 2'd3) state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        octl.start = 1'b1;
        state_next = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        if (odone) state_next = (osign == ORI_NEG) ? ST_SCAN_TOP : ST_SCAN_PUSH;
      end
      ST_SCAN_PUSH: begin
        ow_en = 1'b1; ow_addr = d[IW-1:0]; ow_data = t_idx;
        state_next = (i + CW'(1) < n) ? ST_SCAN_RD : ST_OUT_RD;
      end
      ST_OUT_RD: begin
        or_addr = i[IW-1:0];
        pr_addr = ord;
        if (rd_ph == 2'd2) state_next = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        if (m_fire) state_next = out_last ? ST_LOAD : ST_OUT_RD;
      end
      ST_EMPTY: begin
        if (m_fire) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; n <= '0; i <= '0; j <= '0; d <= '0; rd_ph <= '0;
      out_valid <= 1'b0; out_last <= 1'b0; out_empty <= 1'b0;
      piv <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_fire) begin
            if (s_tlast) begin
              n <= n_load; count <= '0; i <= '0;
              if (n_load < CW'(3)) begin
                out_valid <= 1'b1; out_last <= 1'b1; out_empty <= 1'b1; out_pt <= '0;
                d <= '0;
              end
            end else if (count < CW'(MAX_POINTS)) begin
              count <= count + CW'(1);
            end
          end
        end
        ST_PIV_CMP: begin
          if (i == '0 || less_pt) begin
            piv <= i[IW-1:0]; piv_pt <= prd;
          end
          if (i + CW'(1) != n) i <= i + CW'(1);
        end
        ST_SORT_INIT: begin
          if (rd_ph == 2'd0) rd_ph <= 2'd1;
          else begin
            rd_ph <= '0; i <= CW'(2); a_pt <= piv_pt;
          end
        end
        ST_SORT_T: begin
          if (rd_ph == 2'd1) t_idx <= ord;
          if (rd_ph == 2'd2) begin
            b_pt <= prd; j <= i; rd_ph <= '0;
          end else begin
            rd_ph <= rd_ph + 2'd1;
          end
        end
        ST_SORT_C: begin
          if (rd_ph == 2'd1) c_idx <= ord;
          if (rd_ph == 2'd2) begin
            c_pt <= prd; rd_ph <= '0;
          end else if (!(rd_ph == 2'd0 && j == CW'(1))) begin
            rd_ph <= rd_ph + 2'd1;
          end
        end
        ST_SORT_WAIT: begin
          if (odone && before_t) j <= j - CW'(1);
        end
        ST_SORT_PUT: begin
          if (i + CW'(1) < n) i <= i + CW'(1);
          else begin
            i <= '0; d <= '0;
          end
        end
        ST_SCAN_RD: begin
          if (rd_ph == 2'd1) t_idx <= ord;
          if (rd_ph == 2'd2) begin
            c_pt <= prd; rd_ph <= '0;
          end else begin
            rd_ph <= rd_ph + 2'd1;
          end
        end
        ST_SCAN_TOP: begin
          if (rd_ph == 2'd2) a_pt <= prd;
          if (rd_ph == 2'd3) begin
            b_pt <= prd; rd_ph <= '0;
          end else if (!(rd_ph == 2'd0 && d < CW'(2))) begin
            rd_ph <= rd_ph + 2'd1;
          end
        end
        ST_SCAN_WAIT: begin
          if (odone && osign == ORI_NEG) d <= d - CW'(1);
        end
        ST_SCAN_PUSH: begin
          d <= d + CW'(1);
          if (i + CW'(1) < n) i <= i + CW'(1);
          else i <= '0;
        end
        ST_OUT_RD: begin
          if (rd_ph == 2'd2) begin
            rd_ph <= '0;
            out_valid <= 1'b1; out_pt <= prd; out_empty <= 1'b0;
            out_last <= (i + CW'(1) == d);
          end else begin
            rd_ph <= rd_ph + 2'd1;
          end
        end
        ST_OUT_SHOW: begin
          if (m_fire) begin
            out_valid <= 1'b0; i <= i + CW'(1);
          end
        end
        ST_EMPTY: if (m_fire) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // Checks on internal bookkeeping.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst) d <= CW'(MAX_POINTS))
    else $error("hull stack overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_POINTS))
    else $error("point count overflow");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input accepted while a result waits");
  a_empty_last: assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> m_tlast)
    else $error("empty result not marked last");

endmodule
